// ----- design/atl_pkg.sv -----
// ============================================================================
// atl_pkg
// Shared types, constants and character classes for the assembler token lexer.
// ============================================================================
package atl_pkg;

  // Statement positions count modulo STMT_CHARS, which must be a power of two.
  localparam int STMT_CHARS = 4096;
  localparam int POS_W      = $clog2(STMT_CHARS);

  // Widths of the result fields.
  localparam int CHAR_W    = 8;
  localparam int KIND_W    = 3;
  localparam int TOK_POS_W = 12;
  localparam int ACC_W     = 64;

  // Result queue geometry.
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_IDX_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [TOK_POS_W-1:0] tok_pos_t;
  typedef logic [ACC_W-1:0]     acc_t;

  localparam pos_t POS_ONE = pos_t'(1);

  // Character codes used by the classifier.
  localparam char_t CHAR_EOS        = 8'h00;
  localparam char_t CHAR_TAB        = 8'h09;
  localparam char_t CHAR_CR         = 8'h0D;
  localparam char_t CHAR_SPACE      = 8'h20;
  localparam char_t CHAR_BANG       = 8'h21;
  localparam char_t CHAR_TILDE      = 8'h7E;
  localparam char_t CHAR_ZERO       = 8'h30;
  localparam char_t CHAR_NINE       = 8'h39;
  localparam char_t CHAR_UPPER_A    = 8'h41;
  localparam char_t CHAR_UPPER_Z    = 8'h5A;
  localparam char_t CHAR_LOWER_A    = 8'h61;
  localparam char_t CHAR_LOWER_Z    = 8'h7A;
  localparam char_t CHAR_UNDERSCORE = 8'h5F;
  localparam char_t CHAR_DOT        = 8'h2E;
  localparam char_t CHAR_DOLLAR     = 8'h24;

  // Lexer mode.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_SYM  = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  // Token kinds as reported on the result channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_NUM   = 3'd0,
    KIND_SYM   = 3'd1,
    KIND_PUNCT = 3'd2,
    KIND_END   = 3'd3,
    KIND_BAD   = 3'd4
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t    kind;
    tok_pos_t start;
    tok_pos_t length;
    acc_t     value;
    logic     last;
  } tok_res_t;

  // Write strobes from the lexer core into the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } tok_push_t;

  function automatic tok_pos_t to_tok_pos(input pos_t p);
    return tok_pos_t'(p);
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_space(input char_t c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_sym_char(input char_t c);
    return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           (c == CHAR_UNDERSCORE) || (c == CHAR_DOT) || (c == CHAR_DOLLAR);
  endfunction

  function automatic logic is_punct(input char_t c);
    return (c >= CHAR_BANG) && (c <= CHAR_TILDE) && !is_digit(c) && !is_sym_char(c);
  endfunction

endpackage

// ----- design/atl_core.sv -----
// ============================================================================
// atl_core
// Input register and single-pass lexer step that produces up to two results.
// ============================================================================
module atl_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  atl_pkg::char_t     in_char_code,
  input  logic               room,
  output atl_pkg::tok_push_t push,
  output atl_pkg::tok_res_t  res_a,
  output atl_pkg::tok_res_t  res_b
);

  logic                valid_r, valid_nxt;
  atl_pkg::char_t      char_r;
  atl_pkg::mode_t      mode_r, mode_nxt;
  atl_pkg::pos_t       pos_r, pos_nxt;
  atl_pkg::pos_t       start_r, start_nxt;
  atl_pkg::acc_t       acc_r, acc_nxt;

  logic                adv;
  logic                accept;
  logic                flush_v;
  logic                own_v;
  atl_pkg::tok_res_t   flush_res;
  atl_pkg::tok_res_t   own_res;
  logic [atl_pkg::ACC_W+3:0] acc_wide;
  logic [3:0]          digit;

  assign adv      = valid_r && room;
  assign in_stall = valid_r && !room;
  assign accept   = in_valid && !in_stall;
  assign digit    = char_r[3:0];

  // Decimal accumulate: acc * 10 + digit, with overflow seen in the top bits.
  assign acc_wide = (atl_pkg::ACC_W + 4)'({acc_r, 3'b000}) +
                    (atl_pkg::ACC_W + 4)'({acc_r, 1'b0}) +
                    (atl_pkg::ACC_W + 4)'(digit);

  always_comb begin
    valid_nxt = accept ? 1'b1 : (adv ? 1'b0 : valid_r);
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    acc_nxt   = acc_r;
    flush_v   = 1'b0;
    own_v     = 1'b0;

    flush_res.kind   = (mode_r == atl_pkg::MODE_NUM) ? atl_pkg::KIND_NUM : atl_pkg::KIND_SYM;
    flush_res.start  = atl_pkg::to_tok_pos(start_r);
    flush_res.length = atl_pkg::to_tok_pos(pos_r - start_r);
    flush_res.value  = (mode_r == atl_pkg::MODE_NUM) ? acc_r : '0;
    flush_res.last   = 1'b0;

    own_res.kind   = atl_pkg::KIND_END;
    own_res.start  = atl_pkg::to_tok_pos(pos_r);
    own_res.length = '0;
    own_res.value  = '0;
    own_res.last   = 1'b1;

    if (adv) begin
      pos_nxt = pos_r + atl_pkg::POS_ONE;
      if (char_r == atl_pkg::CHAR_EOS) begin
        flush_v   = (mode_r == atl_pkg::MODE_NUM) || (mode_r == atl_pkg::MODE_SYM);
        own_v     = 1'b1;
        mode_nxt  = atl_pkg::MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
      end else if (mode_r == atl_pkg::MODE_ERR) begin
        // The rest of the statement is dropped.
      end else if (atl_pkg::is_digit(char_r) && (mode_r == atl_pkg::MODE_NUM)) begin
        acc_nxt = (|acc_wide[atl_pkg::ACC_W+3:atl_pkg::ACC_W]) ? '1 :
                  acc_wide[atl_pkg::ACC_W-1:0];
      end else if ((atl_pkg::is_digit(char_r) || atl_pkg::is_sym_char(char_r)) &&
                   (mode_r == atl_pkg::MODE_SYM)) begin
        // Symbol continues.
      end else begin
        flush_v  = (mode_r == atl_pkg::MODE_NUM) || (mode_r == atl_pkg::MODE_SYM);
        mode_nxt = atl_pkg::MODE_IDLE;
        if (atl_pkg::is_space(char_r)) begin
          // Whitespace only separates tokens.
        end else if (atl_pkg::is_digit(char_r)) begin
          mode_nxt  = atl_pkg::MODE_NUM;
          start_nxt = pos_r;
          acc_nxt   = atl_pkg::ACC_W'(digit);
        end else if (atl_pkg::is_sym_char(char_r)) begin
          mode_nxt  = atl_pkg::MODE_SYM;
          start_nxt = pos_r;
        end else if (atl_pkg::is_punct(char_r)) begin
          own_v          = 1'b1;
          own_res.kind   = atl_pkg::KIND_PUNCT;
          own_res.length = atl_pkg::TOK_POS_W'(1);
          own_res.value  = atl_pkg::ACC_W'(char_r);
        end else begin
          own_v         = 1'b1;
          own_res.kind  = atl_pkg::KIND_BAD;
          own_res.value = atl_pkg::ACC_W'(char_r);
          mode_nxt      = atl_pkg::MODE_ERR;
        end
      end
    end

    flush_res.last = !own_v;
    push.first     = flush_v || own_v;
    push.second    = flush_v && own_v;
    res_a          = flush_v ? flush_res : own_res;
    res_b          = own_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mode_r  <= atl_pkg::MODE_IDLE;
      pos_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_char_code;
    end
    start_r <= start_nxt;
    acc_r   <= acc_nxt;
  end

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (mode_r == atl_pkg::MODE_ERR) && (char_r != atl_pkg::CHAR_EOS)) |-> !push.first)
    else $error("atl_core: result produced while ignoring an errored statement");

  a_bad_enters_err: assert property (@(posedge clk) disable iff (!rst_n)
    (push.first && (res_b.kind == atl_pkg::KIND_BAD) && own_v) |=>
      (mode_r == atl_pkg::MODE_ERR))
    else $error("atl_core: invalid character did not enter the error mode");

  a_eos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (char_r == atl_pkg::CHAR_EOS)) |=> ((pos_r == '0) && (mode_r == atl_pkg::MODE_IDLE)))
    else $error("atl_core: end of statement did not restart the position");

endmodule

// ----- design/atl_resq.sv -----
// ============================================================================
// atl_resq
// Four-entry result queue that takes up to two results per cycle.
// ============================================================================
module atl_resq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  atl_pkg::tok_push_t        push,
  input  atl_pkg::tok_res_t         res_a,
  input  atl_pkg::tok_res_t         res_b,
  output logic                      room,
  output logic                      out_valid,
  input  logic                      out_stall,
  output atl_pkg::tok_res_t         head
);

  atl_pkg::tok_res_t                  mem_r [atl_pkg::RESQ_DEPTH];
  logic [atl_pkg::RESQ_IDX_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [atl_pkg::RESQ_IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [atl_pkg::RESQ_CNT_W-1:0]     count_r, count_nxt;
  logic [atl_pkg::RESQ_IDX_W-1:0]     wr_ptr_b;
  logic                               pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rd_ptr_r];
  assign room      = (count_r <= atl_pkg::RESQ_CNT_W'(atl_pkg::RESQ_DEPTH - 2));
  assign wr_ptr_b  = wr_ptr_r + atl_pkg::RESQ_IDX_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + atl_pkg::RESQ_IDX_W'(push.first) +
                 atl_pkg::RESQ_IDX_W'(push.second);
    rd_ptr_nxt = rd_ptr_r + atl_pkg::RESQ_IDX_W'(pop);
    count_nxt  = count_r + atl_pkg::RESQ_CNT_W'(push.first) +
                 atl_pkg::RESQ_CNT_W'(push.second) - atl_pkg::RESQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wr_ptr_r] <= res_a;
    end
    if (push.second) begin
      mem_r[wr_ptr_b] <= res_b;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= atl_pkg::RESQ_CNT_W'(atl_pkg::RESQ_DEPTH))
    else $error("atl_resq: queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> (push.first && room))
    else $error("atl_resq: second write without first or without room");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.first) |=> (count_r == $past(count_r) - 1'b1))
    else $error("atl_resq: count did not drop on a read");

endmodule

// ----- design/assembler_token_lexer.sv -----
// ============================================================================
// assembler_token_lexer
// Streams statement characters in and tokens out, one per cycle unless stalled.
// ============================================================================
// Order: an accepted character is held in the core's input register, and its
// results are written into the result queue and offered from there.
// Throughput: one character per cycle unless stalled; at most one result leaves
// per cycle; a character that ends a token and makes its own gives two results.
// The four-entry result queue bounds input stall to output back-pressure only.
// Reset (synchronous, rst_n low): idle mode, position zero, empty queue.
// ============================================================================
module assembler_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  // Character channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  // Token channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [11:0] out_token_start,
  output logic [11:0] out_token_length,
  output logic [63:0] out_token_value,
  output logic        out_last_in_run
);

  // The core registers each character, then in one pass decides whether it
  // closes a pending number or symbol and whether it produces its own result.
  // Both possible results are written into the queue in the same cycle.
  atl_pkg::tok_push_t push;
  atl_pkg::tok_res_t  res_a;
  atl_pkg::tok_res_t  res_b;
  atl_pkg::tok_res_t  head;
  logic               room;

  atl_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .room         (room),
    .push         (push),
    .res_a        (res_a),
    .res_b        (res_b)
  );

  // The queue parts the two sides: a transaction on the character channel
  // proceeds whenever two entries are free, independent of the token channel.
  atl_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_token_value  = head.value;
  assign out_last_in_run  = head.last;

endmodule

// ----- tb/tb_assembler_token_lexer.sv -----
// ============================================================================
// tb_assembler_token_lexer
// Self-checking bench for the assembler token lexer. Statement characters are
// streamed in under random idle gaps while the token channel is stalled at
// random. Every accepted character is run through a cycle-free model of the
// lexer, and each token that leaves the block is checked field by field
// against the oldest predicted token.
// ============================================================================
module tb_assembler_token_lexer;

  // Scoreboard: holds the lexer state as seen from the character stream and
  // the queue of tokens that the block still owes us.
  class token_scoreboard;
    atl_pkg::tok_res_t expected_tokens[$];
    atl_pkg::tok_res_t fresh[$];
    int unsigned       fails;
    atl_pkg::mode_t    mode;
    atl_pkg::tok_pos_t pos;
    atl_pkg::tok_pos_t tok_start;
    atl_pkg::acc_t     acc;

    function new();
      fails     = 0;
      mode      = atl_pkg::MODE_IDLE;
      pos       = '0;
      tok_start = '0;
      acc       = '0;
    endfunction

    static function bit digit_char(input atl_pkg::char_t c);
      return (c >= atl_pkg::CHAR_ZERO) && (c <= atl_pkg::CHAR_NINE);
    endfunction

    static function bit blank_char(input atl_pkg::char_t c);
      return (c == atl_pkg::CHAR_SPACE) ||
             ((c >= atl_pkg::CHAR_TAB) && (c <= atl_pkg::CHAR_CR));
    endfunction

    static function bit sym_lead(input atl_pkg::char_t c);
      return ((c >= atl_pkg::CHAR_LOWER_A) && (c <= atl_pkg::CHAR_LOWER_Z)) ||
             ((c >= atl_pkg::CHAR_UPPER_A) && (c <= atl_pkg::CHAR_UPPER_Z)) ||
             (c == atl_pkg::CHAR_UNDERSCORE) || (c == atl_pkg::CHAR_DOT) ||
             (c == atl_pkg::CHAR_DOLLAR);
    endfunction

    static function bit punct_char(input atl_pkg::char_t c);
      return (c >= atl_pkg::CHAR_BANG) && (c <= atl_pkg::CHAR_TILDE) &&
             !digit_char(c) && !sym_lead(c);
    endfunction

    function void push_token(input atl_pkg::kind_t kind, input atl_pkg::tok_pos_t start,
                             input atl_pkg::tok_pos_t length, input atl_pkg::acc_t value);
      atl_pkg::tok_res_t t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.value  = value;
      t.last   = 1'b0;
      fresh.push_back(t);
    endfunction

    // Emits the pending number or symbol, if any. Length wraps with position.
    function void close_token();
      if (mode == atl_pkg::MODE_NUM)
        push_token(atl_pkg::KIND_NUM, tok_start, pos - tok_start, acc);
      else if (mode == atl_pkg::MODE_SYM)
        push_token(atl_pkg::KIND_SYM, tok_start, pos - tok_start, '0);
      if (mode != atl_pkg::MODE_ERR)
        mode = atl_pkg::MODE_IDLE;
      acc = '0;
    endfunction

    // Decimal accumulate that sticks at all ones once it would overflow.
    function void add_digit(input atl_pkg::acc_t d);
      atl_pkg::acc_t lim;
      lim = ({atl_pkg::ACC_W{1'b1}} - d) / 10;
      if (acc > lim)
        acc = {atl_pkg::ACC_W{1'b1}};
      else
        acc = acc * 10 + d;
    endfunction

    // Predicts the tokens caused by one accepted character.
    function void note_char(input atl_pkg::char_t c);
      fresh.delete();
      if (c == atl_pkg::CHAR_EOS) begin
        close_token();
        push_token(atl_pkg::KIND_END, pos, '0, '0);
        mode      = atl_pkg::MODE_IDLE;
        pos       = '0;
        tok_start = '0;
      end else begin
        if (mode == atl_pkg::MODE_ERR) begin
          // Rest of the statement is swallowed.
        end else if (digit_char(c) && mode == atl_pkg::MODE_NUM) begin
          add_digit(atl_pkg::acc_t'(c - atl_pkg::CHAR_ZERO));
        end else if ((digit_char(c) || sym_lead(c)) && mode == atl_pkg::MODE_SYM) begin
          // Symbol keeps growing.
        end else begin
          close_token();
          if (blank_char(c)) begin
          end else if (digit_char(c)) begin
            mode      = atl_pkg::MODE_NUM;
            tok_start = pos;
            acc       = atl_pkg::acc_t'(c - atl_pkg::CHAR_ZERO);
          end else if (sym_lead(c)) begin
            mode      = atl_pkg::MODE_SYM;
            tok_start = pos;
          end else if (punct_char(c)) begin
            push_token(atl_pkg::KIND_PUNCT, pos, atl_pkg::tok_pos_t'(1),
                       atl_pkg::acc_t'(c));
          end else begin
            push_token(atl_pkg::KIND_BAD, pos, '0, atl_pkg::acc_t'(c));
            mode = atl_pkg::MODE_ERR;
          end
        end
        pos = pos + 1'b1;
      end
      if (fresh.size() > 0) begin
        fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
      end
    endfunction

    function void compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
        fails++;
        $display("%0t: token %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_token(input logic [2:0] kind, input logic [11:0] start,
                              input logic [11:0] length, input logic [63:0] value,
                              input logic last);
      atl_pkg::tok_res_t want;
      if (expected_tokens.size() == 0) begin
        fails++;
        $display("%0t: unexpected token, expected none, got kind %0d start %0d value %0d",
                 $time, kind, start, value);
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("kind", 64'(want.kind), 64'(kind));
      compare_field("start", 64'(want.start), 64'(start));
      compare_field("length", 64'(want.length), 64'(length));
      compare_field("value", want.value, value);
      compare_field("last_in_run", 64'(want.last), 64'(last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_token_kind;
  logic [11:0] out_token_start;
  logic [11:0] out_token_length;
  logic [63:0] out_token_value;
  logic        out_last_in_run;

  token_scoreboard sb = new();

  // Every accepted character counts toward the overall budget.
  int unsigned chars_sent;
  bit          send_quiet;

  assembler_token_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_token_value  (out_token_value),
    .out_last_in_run  (out_last_in_run)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Pause length shared by sender and receiver: mostly none or short,
  // now and then a long one. In quiet stretches there is no pause at all.
  function automatic int pick_pause(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic atl_pkg::char_t pick_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? atl_pkg::CHAR_SPACE : atl_pkg::char_t'(atl_pkg::CHAR_TAB + r);
  endfunction

  function automatic atl_pkg::char_t pick_digit();
    return atl_pkg::char_t'(atl_pkg::CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic atl_pkg::char_t pick_sym_lead();
    int r;
    r = $urandom_range(0, 54);
    if (r < 26) return atl_pkg::char_t'(atl_pkg::CHAR_LOWER_A + r);
    if (r < 52) return atl_pkg::char_t'(atl_pkg::CHAR_UPPER_A + r - 26);
    if (r == 52) return atl_pkg::CHAR_UNDERSCORE;
    if (r == 53) return atl_pkg::CHAR_DOT;
    return atl_pkg::CHAR_DOLLAR;
  endfunction

  function automatic atl_pkg::char_t pick_sym_more();
    return ($urandom_range(0, 3) == 0) ? pick_digit() : pick_sym_lead();
  endfunction

  function automatic atl_pkg::char_t pick_punct();
    atl_pkg::char_t c;
    do c = atl_pkg::char_t'($urandom_range(atl_pkg::CHAR_BANG, atl_pkg::CHAR_TILDE));
    while (!token_scoreboard::punct_char(c));
    return c;
  endfunction

  // Control codes, DEL and the whole upper half of the code space.
  function automatic atl_pkg::char_t pick_invalid();
    atl_pkg::char_t c;
    do c = atl_pkg::char_t'($urandom_range(1, 255));
    while (token_scoreboard::blank_char(c) || token_scoreboard::digit_char(c) ||
           token_scoreboard::sym_lead(c) || token_scoreboard::punct_char(c));
    return c;
  endfunction

  // Any character that can appear in a clean statement.
  function automatic atl_pkg::char_t pick_text_char();
    case ($urandom_range(0, 3))
      0:       return pick_blank();
      1:       return pick_digit();
      2:       return pick_sym_more();
      default: return pick_punct();
    endcase
  endfunction

  // Offers one character and returns once the transaction has been accepted.
  // Valid is left high so that back-to-back characters need no extra edge.
  task automatic send_char(input atl_pkg::char_t c);
    int gap;
    if ($urandom_range(0, 199) == 0) send_quiet = !send_quiet;
    gap = pick_pause(send_quiet);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_char_code = c;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    sb.note_char(c);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(atl_pkg::char_t'(s[i]));
  endtask

  // Holds the sender off until every predicted token has left the block, then
  // lets the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Short runs most of the time; sometimes a run that overflows 64 bits, and
  // the values right at and just past the saturation point.
  task automatic send_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      send_text("18446744073709551615");
    else if (r < 16)
      send_text("18446744073709551616");
    else if (r < 28)
      repeat ($urandom_range(17, 30)) send_char(pick_digit());
    else
      repeat ($urandom_range(1, 6)) send_char(pick_digit());
  endtask

  task automatic send_symbol();
    send_char(pick_sym_lead());
    repeat ($urandom_range(0, 10)) send_char(pick_sym_more());
  endtask

  // A random statement built from tokens. Separators are sometimes left out
  // so that tokens abut, which exercises the flush-then-start boundary. A
  // small share of tokens is an invalid character followed by noise.
  task automatic send_statement();
    int ntok;
    int sel;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      if ($urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 2)) send_char(pick_blank());
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        send_number();
      end else if (sel < 60) begin
        send_symbol();
      end else if (sel < 88) begin
        send_char(pick_punct());
      end else if (sel < 95) begin
        send_char(pick_invalid());
        repeat ($urandom_range(0, 4)) send_char(atl_pkg::char_t'($urandom_range(1, 255)));
      end
    end
    send_char(atl_pkg::CHAR_EOS);
  endtask

  // One long statement: a symbol of three hundred characters, then mixed
  // text, so that token lengths and positions run well past the short ones.
  task automatic send_long_statement();
    int cnt;
    send_char(pick_sym_lead());
    repeat (299) send_char(pick_sym_more());
    send_char(atl_pkg::CHAR_SPACE);
    cnt = 301;
    while (cnt < 600) begin
      send_char(pick_text_char());
      cnt++;
    end
    send_char(atl_pkg::CHAR_EOS);
  endtask

  // Token channel: every accepted transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_token(out_token_kind, out_token_start, out_token_length,
                     out_token_value, out_last_in_run);
  end

  // Receiver back-pressure: one open cycle, then a random stall stretch.
  initial begin
    int  hold;
    bit  quiet;
    out_stall = 1'b0;
    hold      = 0;
    quiet     = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) quiet = !quiet;
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        hold      = pick_pause(quiet);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run, where every character gives
  // two tokens that each sit out the longest stall.
  initial begin
    #50_000_000;
    $display("tb_assembler_token_lexer NOT OK");
    $finish;
  end

  initial begin
    int stmt;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    chars_sent   = 0;
    send_quiet   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. An empty statement gives a lone end token.
    send_char(atl_pkg::CHAR_EOS);
    // A digit continues a symbol, a letter ends a number, whitespace is
    // skipped, and the punctuator range is hit at both ends.
    send_text("a9\t12b~!");
    send_char(atl_pkg::CHAR_EOS);
    // An invalid character flushes the pending symbol, reports itself, and
    // the character after it is swallowed up to the end of the statement.
    send_text("_.$z");
    send_char(8'h01);
    send_text("q");
    send_char(atl_pkg::CHAR_EOS);
    // Top of the code space, and DEL right after a space.
    send_char(8'hFF);
    send_char(atl_pkg::CHAR_CR);
    send_char(atl_pkg::CHAR_EOS);
    send_char(atl_pkg::CHAR_SPACE);
    send_char(8'h7F);
    send_char(atl_pkg::CHAR_EOS);
    drain();

    send_long_statement();
    drain();

    // Random part, with a full drain of the block every few statements.
    stmt = 0;
    while (chars_sent < 1700) begin
      send_statement();
      stmt++;
      if (stmt % 15 == 0) drain();
    end

    // Wind down: wait for the last tokens, then watch for stray ones.
    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.expected_tokens.size() == 0)
      $display("tb_assembler_token_lexer OK");
    else
      $display("tb_assembler_token_lexer NOT OK");
    $finish;
  end

endmodule
